[src/gnot_pkg.sv]
// ----------------------------------------------------------------------------
// gnot_pkg
// Shared types and constants of the gated nearest object tracker.
// ----------------------------------------------------------------------------
package gnot_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned DEV_W    = 13;
  localparam int unsigned REC_W    = 8;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned CFG_W    = 13;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [DEV_W-1:0] MAX_DEV_RST = 13'd10;
  localparam logic [REC_W-1:0] MIN_REC_RST = 8'd3;
  localparam logic [CNT_W-1:0] CNT_MAX     = 8'd255;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEV = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_REC = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_POINT  = 2'd0,
    CMD_COMMIT = 2'd1,
    CMD_SELECT = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_MATCHED    = 3'd0,
    STS_NEW        = 3'd1,
    STS_DROPPED    = 3'd2,
    STS_COMMITTED  = 3'd3,
    STS_SELECTED   = 3'd4,
    STS_NONE       = 3'd5,
    STS_FRAME_OPEN = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_COMMIT,
    S_DONE
  } state_e;

endpackage

[src/gnot_if.sv]
// ----------------------------------------------------------------------------
// gnot_in_if / gnot_out_if
// Valid/ready channels carrying tracker commands and tracker results.
// ----------------------------------------------------------------------------
interface gnot_in_if
  import gnot_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [CMD_W-1:0]      cmd;
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;

  modport source (output valid, cmd, pos_x, pos_y, input ready);
  modport sink   (input valid, cmd, pos_x, pos_y, output ready);
endinterface

interface gnot_out_if
  import gnot_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned TOTAL_BITS = 7
);
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [COORD_BITS-1:0] sel_x;
  logic [COORD_BITS-1:0] sel_y;
  logic [TOTAL_BITS-1:0] entry_total;

  modport source (output valid, status, sel_x, sel_y, entry_total, input ready);
  modport sink   (input valid, status, sel_x, sel_y, entry_total, output ready);
endinterface

[src/gated_nearest_object_tracker_unit.sv]
// ----------------------------------------------------------------------------
// gated_nearest_object_tracker_unit
// Greedy gated nearest-neighbor tracker with a committed object table.
// ----------------------------------------------------------------------------
// One transaction in, one result out (unused command 3 gives none). A point
// scans the committed table through one distance unit fed by the single
// table read port, stopping early on a match. A select scans the same way;
// if it selects an entry, it then closes the gap left by the removed entry,
// one entry per cycle. A select while a frame is open skips all of this. A
// commit copies matched and new entries into the table, one per cycle. Every
// result is handed to the output register, which holds it while the next
// transaction is taken in. The hand-off waits while an earlier result is
// unaccepted.
module gated_nearest_object_tracker_unit
  import gnot_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 64,
  parameter int unsigned COORD_BITS  = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  gnot_in_if.sink              in_i,
  gnot_out_if.source           out_o
);

  localparam int unsigned IW  = $clog2(MAX_ENTRIES);
  localparam int unsigned CW  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CB  = COORD_BITS;
  localparam int unsigned SQW = 2 * CB;
  localparam int unsigned GW  = 2 * DEV_W;
  localparam int unsigned DW  = (SQW + 1 > GW) ? SQW + 1 : GW;

  // table and frame stores
  logic [CB-1:0]    tbl_x_m [MAX_ENTRIES];
  logic [CB-1:0]    tbl_y_m [MAX_ENTRIES];
  logic [CNT_W-1:0] tbl_c_m [MAX_ENTRIES];
  logic [CB-1:0]    mat_x_m [MAX_ENTRIES];
  logic [CB-1:0]    mat_y_m [MAX_ENTRIES];
  logic [CNT_W-1:0] mat_c_m [MAX_ENTRIES];
  logic [CB-1:0]    frs_x_m [MAX_ENTRIES];
  logic [CB-1:0]    frs_y_m [MAX_ENTRIES];

  logic [CB-1:0]    tbl_rx_q, tbl_ry_q, mat_rx_q, mat_ry_q, frs_rx_q, frs_ry_q;
  logic [CNT_W-1:0] tbl_rc_q, mat_rc_q;

  logic             tbl_re, tbl_we, mat_re, mat_we, frs_re, frs_we;
  logic [IW-1:0]    tbl_ra, tbl_wa, mat_ra, frs_ra;
  logic [CB-1:0]    tbl_wx, tbl_wy, mat_wx, mat_wy;
  logic [CNT_W-1:0] tbl_wc, mat_wc;

  // control state
  state_e           state_q, state_d;
  cmd_e             cmd_q, cmd_d;
  logic [DEV_W-1:0] maxdev_q, maxdev_d;
  logic [REC_W-1:0] minrec_q, minrec_d;
  logic [CW-1:0]    tsize_q, tsize_d, msize_q, msize_d, fsize_q, fsize_d;
  logic             frame_q, frame_d;
  logic [CB-1:0]    act_x_q, act_x_d, act_y_q, act_y_d;
  logic [MAX_ENTRIES-1:0] taken_q, taken_d;
  logic [CW-1:0]    ra_q, ra_d;
  logic             v1_q, v1_d, v2_q, v2_d, s1_q, s1_d, found_q, found_d;
  logic             out_vld_q, out_vld_d;

  // datapath registers
  logic [CB-1:0]    px_q, px_d, py_q, py_d;
  logic [IW-1:0]    i1_q, i1_d, i2_q, i2_d, best_i_q, best_i_d;
  logic [SQW-1:0]   sqx_q, sqx_d, sqy_q, sqy_d;
  logic [CNT_W-1:0] c2_q, c2_d;
  logic [CB-1:0]    x2_q, x2_d, y2_q, y2_d, best_x_q, best_x_d, best_y_q, best_y_d;
  logic [SQW:0]     best_d_q, best_d_d;
  logic [GW-1:0]    gate_q;
  status_e          res_status_q, res_status_d, out_status_q, out_status_d;
  logic [CB-1:0]    res_x_q, res_x_d, res_y_q, res_y_d;
  logic [CB-1:0]    out_x_q, out_x_d, out_y_q, out_y_d;
  logic [CW-1:0]    out_tot_q, out_tot_d;

  // distance unit
  logic [CB-1:0]    ref_x, ref_y, dx, dy;
  logic [SQW:0]     dsum;
  logic             in_gate;
  logic [CW:0]      tot, room;
  logic [CW-1:0]    ra_m1, ra_fr, best_p1;

  assign ref_x   = (cmd_q == CMD_POINT) ? px_q : act_x_q;
  assign ref_y   = (cmd_q == CMD_POINT) ? py_q : act_y_q;
  assign dx      = (ref_x > tbl_rx_q) ? ref_x - tbl_rx_q : tbl_rx_q - ref_x;
  assign dy      = (ref_y > tbl_ry_q) ? ref_y - tbl_ry_q : tbl_ry_q - ref_y;
  assign dsum    = (SQW+1)'(sqx_q) + (SQW+1)'(sqy_q);
  assign in_gate = DW'(dsum) < DW'(gate_q);
  assign tot     = (CW+1)'(msize_q) + (CW+1)'(fsize_q);
  assign room    = (CW+1)'(tsize_q) + (CW+1)'(fsize_q);
  assign ra_m1   = ra_q - CW'(1);
  assign ra_fr   = ra_q - msize_q;
  assign best_p1 = CW'(best_i_q) + CW'(1);

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = out_vld_q;
  assign out_o.status      = out_status_q;
  assign out_o.sel_x       = out_x_q;
  assign out_o.sel_y       = out_y_q;
  assign out_o.entry_total = out_tot_q;

  always_comb begin
    state_d = state_q;   cmd_d = cmd_q;       maxdev_d = maxdev_q; minrec_d = minrec_q;
    tsize_d = tsize_q;   msize_d = msize_q;   fsize_d = fsize_q;   frame_d = frame_q;
    act_x_d = act_x_q;   act_y_d = act_y_q;   taken_d = taken_q;   ra_d = ra_q;
    v1_d = 1'b0;         v2_d = 1'b0;         s1_d = s1_q;         found_d = found_q;
    out_vld_d = out_vld_q;
    px_d = px_q;         py_d = py_q;         i1_d = i1_q;         i2_d = i1_q;
    best_i_d = best_i_q; best_x_d = best_x_q; best_y_d = best_y_q; best_d_d = best_d_q;
    sqx_d = SQW'(dx) * SQW'(dx);
    sqy_d = SQW'(dy) * SQW'(dy);
    c2_d = tbl_rc_q;     x2_d = tbl_rx_q;     y2_d = tbl_ry_q;
    res_status_d = res_status_q; res_x_d = res_x_q; res_y_d = res_y_q;
    out_status_d = out_status_q; out_x_d = out_x_q; out_y_d = out_y_q;
    out_tot_d = out_tot_q;
    tbl_re = 1'b0; tbl_ra = ra_q[IW-1:0];
    tbl_we = 1'b0; tbl_wa = i1_q; tbl_wx = tbl_rx_q; tbl_wy = tbl_ry_q; tbl_wc = tbl_rc_q;
    mat_re = 1'b0; mat_ra = ra_q[IW-1:0];
    mat_we = 1'b0; mat_wx = x2_q; mat_wy = y2_q;
    mat_wc = (c2_q < CNT_MAX) ? c2_q + CNT_W'(1) : CNT_MAX;
    frs_re = 1'b0; frs_ra = ra_fr[IW-1:0]; frs_we = 1'b0;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_DEV: maxdev_d = cfg_data_i[DEV_W-1:0];
        CFG_MIN_REC: minrec_d = cfg_data_i[REC_W-1:0];
        default: ;
      endcase
    end

    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          cmd_d   = cmd_e'(in_i.cmd);
          px_d    = in_i.pos_x;
          py_d    = in_i.pos_y;
          ra_d    = '0;
          found_d = 1'b0;
          res_x_d = '0;
          res_y_d = '0;
          case (in_i.cmd)
            CMD_POINT: begin
              frame_d = 1'b1;
              state_d = S_SCAN;
            end
            CMD_COMMIT: state_d = S_COMMIT;
            CMD_SELECT: begin
              if (frame_q) begin
                res_status_d = STS_FRAME_OPEN;
                state_d      = S_DONE;
              end else begin
                state_d = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        if (ra_q < tsize_q) begin
          tbl_re = 1'b1;
          ra_d   = ra_q + CW'(1);
          v1_d   = 1'b1;
          i1_d   = ra_q[IW-1:0];
        end
        v2_d = v1_q;
        if (cmd_q == CMD_POINT) begin
          if (v2_q && !taken_q[i2_q] && in_gate) begin
            taken_d[i2_q] = 1'b1;
            if (msize_q < CW'(MAX_ENTRIES)) begin
              mat_we  = 1'b1;
              msize_d = msize_q + CW'(1);
            end
            res_status_d = STS_MATCHED;
            v1_d    = 1'b0;
            v2_d    = 1'b0;
            state_d = S_DONE;
          end else if (ra_q >= tsize_q && !v1_q && !v2_q) begin
            if (room >= (CW+1)'(MAX_ENTRIES)) begin
              res_status_d = STS_DROPPED;
            end else begin
              frs_we       = 1'b1;
              fsize_d      = fsize_q + CW'(1);
              res_status_d = STS_NEW;
            end
            state_d = S_DONE;
          end
        end else begin
          if (v2_q && c2_q >= minrec_q && (!found_q || dsum < best_d_q)) begin
            found_d  = 1'b1;
            best_d_d = dsum;
            best_i_d = i2_q;
            best_x_d = x2_q;
            best_y_d = y2_q;
          end
          if (ra_q >= tsize_q && !v1_q && !v2_q) begin
            if (!found_q) begin
              res_status_d = STS_NONE;
              state_d      = S_DONE;
            end else begin
              act_x_d      = best_x_q;
              act_y_d      = best_y_q;
              res_x_d      = best_x_q;
              res_y_d      = best_y_q;
              res_status_d = STS_SELECTED;
              ra_d         = best_p1;
              state_d      = S_SHIFT;
            end
          end
        end
      end

      S_SHIFT: begin
        // read entry i+1 and write it back at i on the next cycle
        if (ra_q < tsize_q) begin
          tbl_re = 1'b1;
          ra_d   = ra_q + CW'(1);
          v1_d   = 1'b1;
          i1_d   = ra_m1[IW-1:0];
        end
        if (v1_q) begin
          tbl_we = 1'b1;
        end
        if (ra_q >= tsize_q && !v1_q) begin
          tsize_d = tsize_q - CW'(1);
          state_d = S_DONE;
        end
      end

      S_COMMIT: begin
        if ((CW+1)'(ra_q) < tot) begin
          if (ra_q < msize_q) begin
            mat_re = 1'b1;
            s1_d   = 1'b0;
          end else begin
            frs_re = 1'b1;
            s1_d   = 1'b1;
          end
          ra_d = ra_q + CW'(1);
          v1_d = 1'b1;
          i1_d = ra_q[IW-1:0];
        end
        if (v1_q) begin
          tbl_we = 1'b1;
          tbl_wx = s1_q ? frs_rx_q : mat_rx_q;
          tbl_wy = s1_q ? frs_ry_q : mat_ry_q;
          tbl_wc = s1_q ? '0 : mat_rc_q;
        end
        if ((CW+1)'(ra_q) >= tot && !v1_q) begin
          tsize_d      = tot[CW-1:0];
          msize_d      = '0;
          fsize_d      = '0;
          taken_d      = '0;
          frame_d      = 1'b0;
          res_status_d = STS_COMMITTED;
          state_d      = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d    = 1'b1;
          out_status_d = res_status_q;
          out_x_d      = res_x_q;
          out_y_d      = res_y_q;
          out_tot_d    = tsize_q;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      maxdev_q  <= MAX_DEV_RST;
      minrec_q  <= MIN_REC_RST;
      tsize_q   <= '0;
      msize_q   <= '0;
      fsize_q   <= '0;
      frame_q   <= 1'b0;
      act_x_q   <= '0;
      act_y_q   <= '0;
      taken_q   <= '0;
      ra_q      <= '0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      s1_q      <= 1'b0;
      found_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      maxdev_q  <= maxdev_d;
      minrec_q  <= minrec_d;
      tsize_q   <= tsize_d;
      msize_q   <= msize_d;
      fsize_q   <= fsize_d;
      frame_q   <= frame_d;
      act_x_q   <= act_x_d;
      act_y_q   <= act_y_d;
      taken_q   <= taken_d;
      ra_q      <= ra_d;
      v1_q      <= v1_d;
      v2_q      <= v2_d;
      s1_q      <= s1_d;
      found_q   <= found_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    px_q         <= px_d;
    py_q         <= py_d;
    i1_q         <= i1_d;
    i2_q         <= i2_d;
    sqx_q        <= sqx_d;
    sqy_q        <= sqy_d;
    c2_q         <= c2_d;
    x2_q         <= x2_d;
    y2_q         <= y2_d;
    best_i_q     <= best_i_d;
    best_x_q     <= best_x_d;
    best_y_q     <= best_y_d;
    best_d_q     <= best_d_d;
    gate_q       <= GW'(maxdev_q) * GW'(maxdev_q);
    res_status_q <= res_status_d;
    res_x_q      <= res_x_d;
    res_y_q      <= res_y_d;
    out_status_q <= out_status_d;
    out_x_q      <= out_x_d;
    out_y_q      <= out_y_d;
    out_tot_q    <= out_tot_d;
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_x_m[tbl_wa] <= tbl_wx;
      tbl_y_m[tbl_wa] <= tbl_wy;
      tbl_c_m[tbl_wa] <= tbl_wc;
    end
    if (tbl_re) begin
      tbl_rx_q <= tbl_x_m[tbl_ra];
      tbl_ry_q <= tbl_y_m[tbl_ra];
      tbl_rc_q <= tbl_c_m[tbl_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mat_we) begin
      mat_x_m[msize_q[IW-1:0]] <= mat_wx;
      mat_y_m[msize_q[IW-1:0]] <= mat_wy;
      mat_c_m[msize_q[IW-1:0]] <= mat_wc;
    end
    if (mat_re) begin
      mat_rx_q <= mat_x_m[mat_ra];
      mat_ry_q <= mat_y_m[mat_ra];
      mat_rc_q <= mat_c_m[mat_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (frs_we) begin
      frs_x_m[fsize_q[IW-1:0]] <= px_q;
      frs_y_m[fsize_q[IW-1:0]] <= py_q;
    end
    if (frs_re) begin
      frs_rx_q <= frs_x_m[frs_ra];
      frs_ry_q <= frs_y_m[frs_ra];
    end
  end

endmodule

[src/gnot_checker.sv]
// ----------------------------------------------------------------------------
// gnot_checker
// Port-level checks of the tracker results, bound to the top level.
// ----------------------------------------------------------------------------
module gnot_checker
  import gnot_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 64,
  parameter int unsigned COORD_BITS  = 12
) (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 out_valid_i,
  input logic                                 out_ready_i,
  input logic [STATUS_W-1:0]                  status_i,
  input logic [COORD_BITS-1:0]                sel_x_i,
  input logic [COORD_BITS-1:0]                sel_y_i,
  input logic [$clog2(MAX_ENTRIES + 1)-1:0]   entry_total_i
);

  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before transaction");

  a_sel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != STS_SELECTED |-> sel_x_i == '0 && sel_y_i == '0)
    else $error("position reported without a select");

  a_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> entry_total_i <= CW'(MAX_ENTRIES))
    else $error("table size beyond capacity");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> status_i <= STS_FRAME_OPEN)
    else $error("undefined status code");

endmodule

bind gated_nearest_object_tracker_unit gnot_checker #(
  .MAX_ENTRIES (MAX_ENTRIES),
  .COORD_BITS  (COORD_BITS)
) u_gnot_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .status_i      (out_o.status),
  .sel_x_i       (out_o.sel_x),
  .sel_y_i       (out_o.sel_y),
  .entry_total_i (out_o.entry_total)
);
